// ===== design/ffva_pkg.sv =====
package ffva_pkg;

    // Default sizing of the area table and the page
    localparam int unsigned MAX_AREAS_DEF   = 16;
    localparam int unsigned PAGE_BITS_DEF   = 12;

    // The search base is aligned to 8 MiB
    localparam int unsigned AREA_ALIGN_BITS = 23;

    // Register index of memory_top on the configuration port
    localparam logic        REG_MEMORY_TOP  = 1'b0;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_SIZE   = 3'd1,
        ST_FULL       = 3'd2,
        ST_MISALIGNED = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_NULL       = 3'd5
    } ffva_status_t;

    // Table read address relative to the walk index
    typedef enum logic [1:0] {
        RD_IDX  = 2'd0,
        RD_PREV = 2'd1,
        RD_NEXT = 2'd2
    } ffva_rd_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic         load;
        logic         rd_en;
        ffva_rd_sel_t rd_sel;
        logic         cand_adv;
        logic         idx_inc;
        logic         idx_dec;
        logic         save_pos;
        logic         wr_shift;
        logic         wr_new;
        logic         count_inc;
        logic         count_dec;
        logic         res_load;
        ffva_status_t res_status;
    } ffva_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_free;
        logic null_addr;
        logic misaligned;
        logic bad_size;
        logic table_full;
        logic at_end;
        logic fit;
        logic match;
        logic overflow;
        logic at_pos;
        logic at_last;
        logic out_busy;
    } ffva_sts_t;

endpackage

// ===== design/ffva_ctrl.sv =====
module ffva_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffva_pkg::ffva_sts_t sts,
    output ffva_pkg::ffva_cmd_t cmd
);
    import ffva_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SEARCH,
        S_COMPARE,
        S_FIT,
        S_SHIFT,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    state_t       state_reg;
    state_t       state_next;
    ffva_status_t status_reg;
    ffva_status_t status_next;

    assign in_ready = (state_reg == S_IDLE);

    // Sequence one request through check, walk, shift and result
    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_IDX;
        cmd.res_status = status_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.is_free) begin
                    if (sts.null_addr) begin
                        status_next = ST_NULL;
                        state_next  = S_DONE;
                    end else if (sts.misaligned) begin
                        status_next = ST_MISALIGNED;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end else begin
                    if (sts.bad_size) begin
                        status_next = ST_BAD_SIZE;
                        state_next  = S_DONE;
                    end else if (sts.table_full) begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (sts.at_end) begin
                    if (sts.is_free) begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_FIT;
                    end
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_IDX;
                    state_next = S_COMPARE;
                end
            end
            S_COMPARE: begin
                if (sts.is_free) begin
                    if (sts.match) begin
                        state_next = S_SHIFT;
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_SEARCH;
                    end
                end else begin
                    if (sts.fit) begin
                        state_next = S_FIT;
                    end else begin
                        cmd.cand_adv = 1'b1;
                        cmd.idx_inc  = 1'b1;
                        state_next   = S_SEARCH;
                    end
                end
            end
            S_FIT: begin
                if (sts.overflow) begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end else begin
                    cmd.save_pos = 1'b1;
                    state_next   = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (sts.is_free) begin
                    if (sts.at_last) begin
                        cmd.count_dec = 1'b1;
                        status_next   = ST_OK;
                        state_next    = S_DONE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_NEXT;
                        state_next = S_SHIFT_WR;
                    end
                end else begin
                    if (sts.at_pos) begin
                        cmd.wr_new    = 1'b1;
                        cmd.count_inc = 1'b1;
                        status_next   = ST_OK;
                        state_next    = S_DONE;
                    end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_PREV;
                        state_next = S_SHIFT_WR;
                    end
                end
            end
            S_SHIFT_WR: begin
                cmd.wr_shift = 1'b1;
                if (sts.is_free) begin
                    cmd.idx_inc = 1'b1;
                end else begin
                    cmd.idx_dec = 1'b1;
                end
                state_next = S_SHIFT;
            end
            S_DONE: begin
                if (!sts.out_busy) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the pending status
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

// ===== design/ffva_dp.sv =====
module ffva_dp #(
    parameter int unsigned MAX_AREAS = ffva_pkg::MAX_AREAS_DEF,
    parameter int unsigned PAGE_BITS = ffva_pkg::PAGE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ffva_pkg::ffva_cmd_t   cmd,
    output ffva_pkg::ffva_sts_t   sts,
    input  logic [31:0]           memory_top,
    input  logic                  req_kind,
    input  logic [31:0]           req_size,
    input  logic [31:0]           req_address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           out_address,
    output ffva_pkg::ffva_status_t out_status
);
    import ffva_pkg::*;

    localparam int unsigned IW   = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
    localparam int unsigned CW   = $clog2(MAX_AREAS + 1);
    localparam int unsigned SPW  = 32 - PAGE_BITS;
    localparam int unsigned SZW  = 33 - PAGE_BITS;
    localparam int unsigned SUMW = 34 - PAGE_BITS;
    localparam int unsigned ALW  = AREA_ALIGN_BITS - PAGE_BITS;

    // Area table
    logic [SPW-1:0] start_mem [MAX_AREAS];
    logic [SZW-1:0] span_mem  [MAX_AREAS];

    logic           kind_reg;
    logic [SZW-1:0] size_pg_reg;
    logic [31:0]    addr_reg;
    logic [SZW-1:0] cand_reg;
    logic [CW-1:0]  idx_reg;
    logic [CW-1:0]  pos_reg;
    logic [CW-1:0]  count_reg;
    logic [SPW-1:0] rd_start_reg;
    logic [SZW-1:0] rd_span_reg;
    logic           out_valid_reg;
    logic [31:0]    out_addr_reg;
    ffva_status_t   out_status_reg;

    logic [32:0]    size_round;
    logic [SZW-1:0] size_pg_next;
    logic [SPW-1:0] mt_pg;
    logic [SZW-1:0] base_sum;
    logic [SZW-1:0] base_pg;
    logic [SUMW-1:0] end_sum;
    logic [CW-1:0]  idx_p1;
    logic [CW-1:0]  idx_m1;
    logic [CW-1:0]  rd_idx;
    logic [IW-1:0]  rd_addr;
    logic [IW-1:0]  wr_addr;
    logic [SPW-1:0] wr_start;
    logic [SZW-1:0] wr_span;
    logic           wr_en;

    // Round the request up to whole pages without wrapping
    assign size_round   = {1'b0, req_size} + 33'((64'd1 << PAGE_BITS) - 64'd1);
    assign size_pg_next = size_round[32:PAGE_BITS];

    // Search base: memory top plus 8 MiB, aligned down, in pages
    assign mt_pg    = memory_top[31:PAGE_BITS];
    assign base_sum = {1'b0, mt_pg} + SZW'(64'd1 << ALW);
    assign base_pg  = base_sum & ~SZW'((64'd1 << ALW) - 64'd1);

    // Candidate end, in pages
    assign end_sum = {1'b0, cand_reg} + {1'b0, size_pg_reg};

    assign idx_p1 = idx_reg + CW'(1);
    assign idx_m1 = idx_reg - CW'(1);

    always_comb begin
        case (cmd.rd_sel)
            RD_IDX:  rd_idx = idx_reg;
            RD_PREV: rd_idx = idx_m1;
            RD_NEXT: rd_idx = idx_p1;
            default: rd_idx = idx_reg;
        endcase
    end

    assign rd_addr  = rd_idx[IW-1:0];
    assign wr_addr  = idx_reg[IW-1:0];
    assign wr_en    = cmd.wr_shift | cmd.wr_new;
    assign wr_start = cmd.wr_new ? cand_reg[SPW-1:0] : rd_start_reg;
    assign wr_span  = cmd.wr_new ? (size_pg_reg + SZW'(1)) : rd_span_reg;

    // Table memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            start_mem[wr_addr] <= wr_start;
            span_mem[wr_addr]  <= wr_span;
        end
        if (cmd.rd_en) begin
            rd_start_reg <= start_mem[rd_addr];
            rd_span_reg  <= span_mem[rd_addr];
        end
    end

    // Request, candidate and walk index
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg    <= req_kind;
            size_pg_reg <= size_pg_next;
            addr_reg    <= req_address;
            cand_reg    <= base_pg;
            idx_reg     <= '0;
        end else begin
            if (cmd.cand_adv) begin
                cand_reg <= {1'b0, rd_start_reg} + rd_span_reg;
            end
            if (cmd.save_pos) begin
                pos_reg <= idx_reg;
                idx_reg <= count_reg;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_p1;
            end else if (cmd.idx_dec) begin
                idx_reg <= idx_m1;
            end
        end
    end

    // Fill count of the table
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.count_inc) begin
            count_reg <= count_reg + CW'(1);
        end else if (cmd.count_dec) begin
            count_reg <= count_reg - CW'(1);
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            out_status_reg <= cmd.res_status;
            if (cmd.res_status == ST_OK && !kind_reg) begin
                out_addr_reg <= {cand_reg[SPW-1:0], {PAGE_BITS{1'b0}}};
            end else begin
                out_addr_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_address = out_addr_reg;
    assign out_status  = out_status_reg;

    // Status toward the controller
    always_comb begin
        sts            = '0;
        sts.is_free    = kind_reg;
        sts.null_addr  = (addr_reg == 32'd0);
        sts.misaligned = (addr_reg[PAGE_BITS-1:0] != '0);
        sts.bad_size   = (size_pg_reg == '0) || (size_pg_reg > {1'b0, mt_pg});
        sts.table_full = (count_reg == CW'(MAX_AREAS));
        sts.at_end     = (idx_reg == count_reg);
        sts.fit        = (end_sum < SUMW'(rd_start_reg));
        sts.match      = (rd_start_reg == addr_reg[31:PAGE_BITS]);
        sts.overflow   = (end_sum[SUMW-1:SPW] != '0);
        sts.at_pos     = (idx_reg == pos_reg);
        sts.at_last    = (idx_p1 >= count_reg);
        sts.out_busy   = out_valid_reg && !out_ready;
    end

endmodule

// ===== design/first_fit_virtual_area_allocator_core.sv =====
// First-fit virtual area allocator. Each request beat carries kind in s_tuser (0 allocate,
// 1 free) and size and address in s_tdata; each gives exactly one result beat with the new
// area's start address (zero unless an allocate succeeds) and a status code. Requests are
// handled one at a time. An allocate walks past the table entries in front of its place and,
// when it lands in front of an existing entry, moves the entries behind it up to make room; it
// is refused when it runs out of address space. A free walks to its entry and moves the
// entries behind it down, or misses. A request can also be refused on its size, a full table,
// a null or a misaligned address before any walk. The block returns to idle before it takes
// the next request. The area table is single-port with a registered read, so each entry
// takes a read state and a compare or write state, both in the walk and in the shift. A
// finished result waits in an output register, so a new request can start while it is still
// unclaimed; the next result then holds until the waiting one is taken. The memory_top
// register (byte address 0) should be written only while no request is in flight.
module first_fit_virtual_area_allocator_core #(
    parameter int unsigned MAX_AREAS = ffva_pkg::MAX_AREAS_DEF,
    parameter int unsigned PAGE_BITS = ffva_pkg::PAGE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] size_bytes, [63:32] address
    input  logic [0:0]  s_tuser,   // [0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] area_address, [34:32] status, [39:35] zero

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ffva_pkg::*;

    localparam logic [31:0] MEMORY_TOP_RESET = 32'd16777216;

    logic         sel_memory_top;
    logic [31:0]  memory_top_reg;
    logic         cfg_wr;
    logic         cfg_idx;
    ffva_cmd_t    cmd;
    ffva_sts_t    sts;
    logic [31:0]  out_address;
    ffva_status_t out_status;

    // Register file decode
    assign pready  = 1'b1;
    assign cfg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_top_reg <= MEMORY_TOP_RESET;
        end else if (cfg_wr && cfg_idx == REG_MEMORY_TOP) begin
            memory_top_reg <= pwdata;
        end
    end

    assign sel_memory_top = (cfg_idx == REG_MEMORY_TOP);
    assign prdata         = sel_memory_top ? memory_top_reg : 32'd0;

    ffva_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffva_dp #(
        .MAX_AREAS (MAX_AREAS),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .memory_top  (memory_top_reg),
        .req_kind    (s_tuser[0]),
        .req_size    (s_tdata[31:0]),
        .req_address (s_tdata[63:32]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_address (out_address),
        .out_status  (out_status)
    );

    // Pack the result beat
    assign m_tdata = {5'd0, out_status, out_address};

endmodule
